[design/vlda_pkg.sv]
// ----------------------------------------------------------------------------
// vlda_pkg
// shared constants, types and helpers of the vertical line doubler
// ----------------------------------------------------------------------------
package vlda_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int PIX_W     = 8;
	localparam int COL_W     = 11;
	localparam int ROW_W     = 11;
	localparam int DIM_W     = 12;
	localparam int CFG_IDX_W = 4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 4'd0,
		REG_DST_WIDTH  = 4'd1,
		REG_SRC_HEIGHT = 4'd2,
		REG_DST_HEIGHT = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] ncols;
		logic [ROW_W-1:0] nrows;
		logic             any_rows;
	} geom_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] pix;
		logic [PIX_W-1:0] mean;
		logic             has_mean;
	} entry_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
	                                               input logic [DIM_W-1:0] max);
		clamp_dim = (v > max) ? max : v;
	endfunction

endpackage

[design/vlda_if.sv]
// ----------------------------------------------------------------------------
// vlda interfaces
// pixel, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface vlda_pix_if;
	logic                       valid;
	logic                       ready;
	logic [vlda_pkg::PIX_W-1:0] pixel;
	logic                       frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface vlda_res_if;
	logic                       valid;
	logic                       ready;
	logic [vlda_pkg::ROW_W-1:0] out_row;
	logic [vlda_pkg::COL_W-1:0] out_col;
	logic [vlda_pkg::PIX_W-1:0] value;
	logic                       last;

	modport source (output valid, output out_row, output out_col, output value,
		output last, input ready);
	modport sink (input valid, input out_row, input out_col, input value,
		input last, output ready);
endinterface

interface vlda_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [vlda_pkg::CFG_IDX_W-1:0] index;
	logic [vlda_pkg::DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/vlda_cfg.sv]
// ----------------------------------------------------------------------------
// vlda_cfg
// configuration registers and derived frame geometry
// ----------------------------------------------------------------------------
module vlda_cfg (
	input  logic                clk,
	input  logic                arst_n,
	vlda_cfg_if.sink            cfg,
	output vlda_pkg::geom_t     geom
);

	logic [vlda_pkg::DIM_W-1:0] src_width_q;
	logic [vlda_pkg::DIM_W-1:0] dst_width_q;
	logic [vlda_pkg::DIM_W-1:0] src_height_q;
	logic [vlda_pkg::DIM_W-1:0] dst_height_q;

	logic [vlda_pkg::DIM_W-1:0] sw, dw, sh, dh;
	logic [vlda_pkg::ROW_W-1:0] half;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= vlda_pkg::DIM_W'(640);
			dst_width_q  <= vlda_pkg::DIM_W'(640);
			src_height_q <= vlda_pkg::DIM_W'(480);
			dst_height_q <= vlda_pkg::DIM_W'(960);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				vlda_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg.data;
				vlda_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg.data;
				vlda_pkg::REG_SRC_HEIGHT: src_height_q <= cfg.data;
				vlda_pkg::REG_DST_HEIGHT: dst_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		sw = vlda_pkg::clamp_dim(src_width_q, vlda_pkg::DIM_W'(vlda_pkg::MAX_WIDTH));
		dw = vlda_pkg::clamp_dim(dst_width_q, vlda_pkg::DIM_W'(vlda_pkg::MAX_WIDTH));
		sh = vlda_pkg::clamp_dim(src_height_q, vlda_pkg::DIM_W'(vlda_pkg::MAX_HEIGHT));
		dh = vlda_pkg::clamp_dim(dst_height_q, vlda_pkg::DIM_W'(vlda_pkg::MAX_HEIGHT));

		half = dh[vlda_pkg::DIM_W-1:1];
		if (!dh[0]) begin
			half = half - vlda_pkg::ROW_W'(1);
		end

		geom.src_width = sw;
		geom.ncols     = (sw < dw) ? sw : dw;
		geom.any_rows  = (sh != '0) && (dh != '0);
		geom.nrows     = '0;
		if (sh > vlda_pkg::DIM_W'(1) && dh > vlda_pkg::DIM_W'(1)) begin
			if (sh <= {1'b0, half}) begin
				geom.nrows = vlda_pkg::ROW_W'(sh - vlda_pkg::DIM_W'(1));
			end else begin
				geom.nrows = half;
			end
		end
	end

endmodule

[design/vlda_front.sv]
// ----------------------------------------------------------------------------
// vlda_front
// pixel intake: raster counters, line store and classification of each beat
// ----------------------------------------------------------------------------
module vlda_front (
	input  logic             clk,
	input  logic             arst_n,
	vlda_pix_if.sink         src,
	input  vlda_pkg::geom_t  geom,
	input  logic             push_ready,
	output logic             push_valid,
	output vlda_pkg::entry_t push_entry
);

	logic [vlda_pkg::COL_W-1:0] col_q;
	logic [vlda_pkg::ROW_W-1:0] row_q;
	logic [vlda_pkg::PIX_W-1:0] line_mem [vlda_pkg::MAX_WIDTH];

	logic                       valid_s1;
	logic                       emit_s1;
	logic                       has_mean_s1;
	logic [vlda_pkg::ROW_W-1:0] row_s1;
	logic [vlda_pkg::COL_W-1:0] col_s1;
	logic [vlda_pkg::PIX_W-1:0] pix_s1;
	logic [vlda_pkg::PIX_W-1:0] prev_s1;

	logic [vlda_pkg::COL_W-1:0] cur_col;
	logic [vlda_pkg::ROW_W-1:0] cur_row;
	logic [vlda_pkg::DIM_W-1:0] col_inc;
	logic                       wrap;
	logic                       in_range;
	logic                       accept;
	logic                       advance;
	logic [vlda_pkg::PIX_W:0]   sum;

	always_comb begin
		cur_col  = src.frame_start ? '0 : col_q;
		cur_row  = src.frame_start ? '0 : row_q;
		col_inc  = {1'b0, cur_col} + vlda_pkg::DIM_W'(1);
		wrap     = (col_inc >= geom.src_width) ||
		           (col_inc == vlda_pkg::DIM_W'(vlda_pkg::MAX_WIDTH));
		in_range = geom.any_rows && ({1'b0, cur_col} < geom.ncols) &&
		           (cur_row <= geom.nrows);
	end

	assign advance    = !valid_s1 || !emit_s1 || push_ready;
	assign src.ready  = advance;
	assign accept     = src.valid && advance;
	assign push_valid = valid_s1 && emit_s1;

	always_comb begin
		sum                 = {1'b0, prev_s1} + {1'b0, pix_s1};
		push_entry.row      = row_s1;
		push_entry.col      = col_s1;
		push_entry.pix      = pix_s1;
		push_entry.mean     = sum[vlda_pkg::PIX_W:1];
		push_entry.has_mean = has_mean_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= accept;
			end
			if (accept) begin
				if (wrap) begin
					col_q <= '0;
					row_q <= (cur_row != '1) ? cur_row + vlda_pkg::ROW_W'(1) : cur_row;
				end else begin
					col_q <= col_inc[vlda_pkg::COL_W-1:0];
					row_q <= cur_row;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= in_range;
			has_mean_s1 <= (cur_row != '0);
			row_s1      <= cur_row;
			col_s1      <= cur_col;
			pix_s1      <= src.pixel;
		end
	end

	// line store: old value read out as the new pixel goes in
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_s1           <= line_mem[cur_col];
			line_mem[cur_col] <= src.pixel;
		end
	end

endmodule

[design/vlda_queue.sv]
// ----------------------------------------------------------------------------
// vlda_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module vlda_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  vlda_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop,
	output vlda_pkg::entry_t head
);

	vlda_pkg::entry_t            mem_q [vlda_pkg::QDEPTH];
	logic [vlda_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [vlda_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [vlda_pkg::QCNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (count_q != vlda_pkg::QCNT_W'(vlda_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + vlda_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + vlda_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + vlda_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - vlda_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[design/vlda_back.sv]
// ----------------------------------------------------------------------------
// vlda_back
// expands each queued beat into a mean write (rows past 0) and a copy write
// ----------------------------------------------------------------------------
module vlda_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop,
	input  vlda_pkg::entry_t head,
	vlda_res_if.source       dst
);

	logic                       phase_q;
	logic                       out_valid_q;
	logic [vlda_pkg::ROW_W-1:0] out_row_q;
	logic [vlda_pkg::COL_W-1:0] out_col_q;
	logic [vlda_pkg::PIX_W-1:0] value_q;
	logic                       last_q;

	logic                       load;
	logic                       mean_beat;
	logic [vlda_pkg::ROW_W-1:0] copy_row;

	assign load      = pop_valid && (!out_valid_q || dst.ready);
	assign mean_beat = head.has_mean && !phase_q;
	assign pop       = load && !mean_beat;
	assign copy_row  = head.row << 1;

	assign dst.valid   = out_valid_q;
	assign dst.out_row = out_row_q;
	assign dst.out_col = out_col_q;
	assign dst.value   = value_q;
	assign dst.last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= mean_beat;
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_col_q <= head.col;
			if (mean_beat) begin
				out_row_q <= copy_row - vlda_pkg::ROW_W'(1);
				value_q   <= head.mean;
				last_q    <= 1'b0;
			end else begin
				out_row_q <= copy_row;
				value_q   <= head.pix;
				last_q    <= 1'b1;
			end
		end
	end

endmodule

[design/vertical_line_doubler_averaging.sv]
// ----------------------------------------------------------------------------
// vertical_line_doubler_averaging
// 2x vertical upscaler with line averaging, emitting addressed pixel writes
// ----------------------------------------------------------------------------
// Source pixels enter in raster order, one beat per cycle at most. Source row
// r is written to output row 2r and, from row 1 on, output row 2r-1 first gets
// the truncated mean of rows r-1 and r. The front stage counts columns and
// rows, reads and updates a 2048 x 8 line store and classifies each beat; a
// four-entry queue decouples it from the back stage, which sends one write
// per cycle while the result channel is ready. A pixel in a used row past
// row 0 makes two writes, a row 0 pixel one, and a pixel outside the used
// region none, so the result port bounds the pixel rate. An accepted pixel
// passes the front register, the queue and the back output register before
// its first write. Configuration writes are taken at any time but must only
// be made while the block is idle; the output frame is not cleared here.
// ----------------------------------------------------------------------------
module vertical_line_doubler_averaging (
	input logic        clk,
	input logic        arst_n,
	vlda_pix_if.sink   src,
	vlda_res_if.source dst,
	vlda_cfg_if.sink   cfg
);

	vlda_pkg::geom_t  geom;
	vlda_pkg::entry_t push_entry;
	vlda_pkg::entry_t head;
	logic             push_valid;
	logic             push_ready;
	logic             pop_valid;
	logic             pop;

	vlda_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.geom   (geom)
	);

	vlda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.geom       (geom),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	vlda_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.head       (head)
	);

	vlda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.head      (head),
		.dst       (dst)
	);

endmodule

[dv/vertical_line_doubler_averaging_tb.sv]
// ----------------------------------------------------------------------------
// vertical_line_doubler_averaging_tb
// Self-checking bench for the 2x vertical line doubler with line averaging.
// A scoreboard class predicts every addressed write from the pixels that were
// taken and the current geometry, then matches the result beats in order.
// Directed frames cover the special geometries. Randomized frames follow,
// with stalls on both channels and a calm stretch at the end.
// ----------------------------------------------------------------------------
module vertical_line_doubler_averaging_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vlda_pkg::*;

	localparam int RANDOM_PIXELS = 1150;
	localparam int CALM_PIXELS   = 250;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int ROW_MAX       = (1 << ROW_W) - 1;
	localparam int DIM_MAX       = (1 << DIM_W) - 1;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] value;
		logic             last;
	} pix_write_t;

	class doubler_checker;
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] dst_width;
		logic [DIM_W-1:0] src_height;
		logic [DIM_W-1:0] dst_height;
		logic [PIX_W-1:0] line_store [MAX_WIDTH];
		int unsigned      col_pos;
		int unsigned      row_pos;
		pix_write_t       pending_writes [$];
		int unsigned      pixels_taken;
		int unsigned      writes_checked;
		int unsigned      mismatches;

		function new();
			src_width  = 640;
			dst_width  = 640;
			src_height = 480;
			dst_height = 960;
			foreach (line_store[i]) line_store[i] = '0;
			col_pos        = 0;
			row_pos        = 0;
			pixels_taken   = 0;
			writes_checked = 0;
			mismatches     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
			case (idx)
				REG_SRC_WIDTH:  src_width  = data;
				REG_DST_WIDTH:  dst_width  = data;
				REG_SRC_HEIGHT: src_height = data;
				REG_DST_HEIGHT: dst_height = data;
				default: ;
			endcase
		endfunction

		function void take_pixel(logic [PIX_W-1:0] pixel, logic frame_start);
			int unsigned sw, dw, sh, dh, ncols, nrows, r, c, mean;
			pix_write_t  w;
			sw    = (src_width > MAX_WIDTH) ? MAX_WIDTH : src_width;
			dw    = (dst_width > MAX_WIDTH) ? MAX_WIDTH : dst_width;
			sh    = (src_height > MAX_HEIGHT) ? MAX_HEIGHT : src_height;
			dh    = (dst_height > MAX_HEIGHT) ? MAX_HEIGHT : dst_height;
			ncols = (sw < dw) ? sw : dw;
			nrows = 0;
			pixels_taken++;
			if (frame_start) begin
				col_pos = 0;
				row_pos = 0;
			end
			r = row_pos;
			c = col_pos % MAX_WIDTH;
			if (sh > 1 && dh > 1) begin
				nrows = dh / 2;
				if (dh % 2 == 0)
					nrows--;
				if (sh <= nrows)
					nrows = sh - 1;
			end
			if (sh != 0 && dh != 0 && c < ncols && r <= nrows) begin
				if (r >= 1) begin
					mean    = (int'(line_store[c]) + int'(pixel)) >> 1;
					w.row   = ROW_W'(2 * r - 1);
					w.col   = COL_W'(c);
					w.value = PIX_W'(mean);
					w.last  = 1'b0;
					pending_writes.insert(pending_writes.size(), w);
				end
				w.row   = ROW_W'(2 * r);
				w.col   = COL_W'(c);
				w.value = pixel;
				w.last  = 1'b1;
				pending_writes.insert(pending_writes.size(), w);
			end
			line_store[c] = pixel;
			col_pos++;
			if (col_pos >= sw || col_pos >= MAX_WIDTH) begin
				col_pos = 0;
				if (row_pos < ROW_MAX)
					row_pos++;
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_write(pix_write_t got);
			pix_write_t want;
			if (pending_writes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected write, expected none, actual row %0d col %0d value %0d last %0d",
					$time, got.row, got.col, got.value, got.last);
			end else begin
				want = pending_writes.pop_front();
				writes_checked++;
				compare_field("out_row", want.row, got.row);
				compare_field("out_col", want.col, got.col);
				compare_field("value", want.value, got.value);
				compare_field("last", want.last, got.last);
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	bit             calm;
	int unsigned    idle_cycles;
	int unsigned    geometries;
	doubler_checker model = new();

	vlda_pix_if pix_bus ();
	vlda_res_if wr_bus ();
	vlda_cfg_if cfg_bus ();

	vertical_line_doubler_averaging dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (pix_bus),
		.dst    (wr_bus),
		.cfg    (cfg_bus)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// write channel back-pressure
	initial begin
		wr_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				wr_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				wr_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (wr_bus.valid && wr_bus.ready) begin
			pix_write_t w;
			w.row   = wr_bus.out_row;
			w.col   = wr_bus.out_col;
			w.value = wr_bus.value;
			w.last  = wr_bus.last;
			model.check_write(w);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_bus.valid && pix_bus.ready) || (wr_bus.valid && wr_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	task automatic drain_results();
		pix_bus.valid <= 1'b0;
		@(posedge clk);
		while (model.pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] value, input logic first);
		if (!calm && $urandom_range(0, 5) == 0) begin
			pix_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pix_bus.valid       <= 1'b1;
		pix_bus.pixel       <= value;
		pix_bus.frame_start <= first;
		do @(posedge clk); while (!pix_bus.ready);
		model.take_pixel(value, first);
	endtask

	task automatic send_frame(input int unsigned n, input bit noisy);
		logic [PIX_W-1:0] value;
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: value = '0;
				1: value = '1;
				default: value = PIX_W'($urandom_range(0, 255));
			endcase
			send_pixel(value, i == 0 || (noisy && $urandom_range(0, 39) == 0));
			if (!calm && $urandom_range(0, 199) == 0)
				drain_results();
		end
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		model.write_reg(idx, data);
	endtask

	task automatic set_geometry(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] dw,
		input logic [DIM_W-1:0] sh, input logic [DIM_W-1:0] dh);
		cfg_beat(REG_SRC_WIDTH, sw);
		cfg_beat(REG_DST_WIDTH, dw);
		cfg_beat(REG_SRC_HEIGHT, sh);
		cfg_beat(REG_DST_HEIGHT, dh);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
		geometries++;
	endtask

	function automatic logic [DIM_W-1:0] pick_dim(input int unsigned top);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_W'($urandom_range(MAX_HEIGHT, DIM_MAX));
			default: return DIM_W'($urandom_range(1, top));
		endcase
	endfunction

	task automatic random_phase();
		logic [DIM_W-1:0] sw, dw, sh, dh;
		int unsigned      frames, n;
		sw = ($urandom_range(0, 15) == 0) ? '0 : DIM_W'($urandom_range(1, 9));
		dw = pick_dim(10);
		sh = pick_dim(10);
		dh = pick_dim(20);
		set_geometry(sw, dw, sh, dh);
		frames = $urandom_range(1, 3);
		repeat (frames) begin
			n = ((sw == 0) ? 1 : sw) * $urandom_range(1, 12);
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, n);
			send_frame(n, $urandom_range(0, 3) == 0);
		end
		drain_results();
	endtask

	initial begin
		int unsigned start;
		calm                = 1'b0;
		geometries          = 0;
		pix_bus.valid       <= 1'b0;
		pix_bus.pixel       <= '0;
		pix_bus.frame_start <= 1'b0;
		cfg_bus.valid       <= 1'b0;
		cfg_bus.index       <= REG_SRC_WIDTH;
		cfg_bus.data        <= '0;
		arst_n              <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry, counters from reset
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h5A, 1'b0);
		drain_results();
		cfg_beat(CFG_IDX_W'($urandom_range(REG_DST_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
			DIM_W'($urandom_range(0, DIM_MAX)));

		// even dst height, narrow dst, truncating mean
		set_geometry(3, 2, 3, 4);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h11, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'h22, 1'b0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h80, 1'b0);
		drain_results();

		// zero source width, zero heights
		set_geometry(0, 5, 4, 8);
		send_pixel(8'hC3, 1'b1);
		send_pixel(8'h3C, 1'b0);
		drain_results();
		set_geometry(2, 2, 0, 6);
		send_pixel(8'h77, 1'b1);
		send_pixel(8'h88, 1'b0);
		drain_results();
		set_geometry(2, 2, 4, 0);
		send_pixel(8'h99, 1'b1);
		send_pixel(8'h66, 1'b0);
		drain_results();

		// odd dst height, then reframe mid-frame
		set_geometry(2, 4, 5, 5);
		send_pixel(8'h10, 1'b1);
		send_pixel(8'hF0, 1'b0);
		send_pixel(8'h20, 1'b0);
		send_pixel(8'hE1, 1'b0);
		send_pixel(8'h30, 1'b0);
		send_pixel(8'hD2, 1'b0);
		send_pixel(8'h3C, 1'b1);
		drain_results();

		// height of one
		set_geometry(1, 1, 1, 4);
		send_pixel(8'hAA, 1'b1);
		send_pixel(8'h55, 1'b0);
		drain_results();

		// oversized heights, tall narrow frame
		set_geometry(1, DIM_MAX, DIM_MAX, DIM_MAX);
		send_frame(200, 1'b0);
		drain_results();

		// oversized source width
		set_geometry(DIM_MAX, DIM_W'(MAX_WIDTH), 2, 3);
		send_frame(300, 1'b0);
		drain_results();

		start = model.pixels_taken;
		while (model.pixels_taken < start + RANDOM_PIXELS) begin
			calm = (model.pixels_taken >= start + RANDOM_PIXELS - CALM_PIXELS);
			random_phase();
		end
		drain_results();

		$display("summary: %0d pixels over %0d geometries, %0d writes checked",
			model.pixels_taken, geometries, model.writes_checked);
		$display("summary: zero, single and oversized sizes, mid-frame restarts, stalls");
		if (model.mismatches == 0 && model.pending_writes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
